// ===== rtl/chip8_instruction_decoder_macros.svh =====
// Assertion macros shared by the CHIP-8 instruction decoder RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef CHIP8_INSTRUCTION_DECODER_MACROS_SVH
`define CHIP8_INSTRUCTION_DECODER_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define C8D_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define C8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/c8dec_pkg.sv =====
// Package for the CHIP-8 instruction decoder: class codes, widths and the
// decode result structure. No dependencies.
package c8dec_pkg;

  localparam int RegCount   = 16;
  localparam int ClassWidth = 6;

  typedef logic [ClassWidth-1:0] class_t;
  typedef logic [RegCount-1:0]   reg_mask_t;

  // Instruction classes, numbered densely
  localparam class_t CLS_CLS     = 6'd0;
  localparam class_t CLS_RET     = 6'd1;
  localparam class_t CLS_JP      = 6'd2;
  localparam class_t CLS_CALL    = 6'd3;
  localparam class_t CLS_SE_KK   = 6'd4;
  localparam class_t CLS_SNE_KK  = 6'd5;
  localparam class_t CLS_SE_XY   = 6'd6;
  localparam class_t CLS_LD_KK   = 6'd7;
  localparam class_t CLS_ADD_KK  = 6'd8;
  localparam class_t CLS_LD_XY   = 6'd9;
  localparam class_t CLS_OR      = 6'd10;
  localparam class_t CLS_AND     = 6'd11;
  localparam class_t CLS_XOR     = 6'd12;
  localparam class_t CLS_ADD_XY  = 6'd13;
  localparam class_t CLS_SUB     = 6'd14;
  localparam class_t CLS_SHR     = 6'd15;
  localparam class_t CLS_SUBN    = 6'd16;
  localparam class_t CLS_SHL     = 6'd17;
  localparam class_t CLS_SNE_XY  = 6'd18;
  localparam class_t CLS_LD_I    = 6'd19;
  localparam class_t CLS_JP_V0   = 6'd20;
  localparam class_t CLS_RND     = 6'd21;
  localparam class_t CLS_DRW     = 6'd22;
  localparam class_t CLS_SKP     = 6'd23;
  localparam class_t CLS_SKNP    = 6'd24;
  localparam class_t CLS_LD_DT_R = 6'd25;
  localparam class_t CLS_LD_KEY  = 6'd26;
  localparam class_t CLS_LD_DT_W = 6'd27;
  localparam class_t CLS_LD_ST   = 6'd28;
  localparam class_t CLS_ADD_I   = 6'd29;
  localparam class_t CLS_LD_F    = 6'd30;
  localparam class_t CLS_LD_BCD  = 6'd31;
  localparam class_t CLS_STORE   = 6'd32;
  localparam class_t CLS_LOAD    = 6'd33;
  localparam class_t CLS_UNKNOWN = 6'd34;

  // Opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SEXY = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNXY = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  // Fixed opcodes and low-byte selectors
  localparam logic [15:0] OP_CLS   = 16'h00E0;
  localparam logic [15:0] OP_RET   = 16'h00EE;
  localparam logic [7:0]  KK_SKP   = 8'h9E;
  localparam logic [7:0]  KK_SKNP  = 8'hA1;
  localparam logic [7:0]  KK_DT_R  = 8'h07;
  localparam logic [7:0]  KK_KEY   = 8'h0A;
  localparam logic [7:0]  KK_DT_W  = 8'h15;
  localparam logic [7:0]  KK_ST    = 8'h18;
  localparam logic [7:0]  KK_ADD_I = 8'h1E;
  localparam logic [7:0]  KK_F     = 8'h29;
  localparam logic [7:0]  KK_BCD   = 8'h33;
  localparam logic [7:0]  KK_STORE = 8'h55;
  localparam logic [7:0]  KK_LOAD  = 8'h65;
  localparam logic [3:0]  N_SHL    = 4'hE;

  // VF is the carry / collision flag register
  localparam reg_mask_t VF_MASK = reg_mask_t'(1) << (RegCount - 1);

  // Decode result passed from the decode logic to the result register
  typedef struct packed {
    class_t    instr_class;
    reg_mask_t used_regs;
    logic      ends_block;
    logic      writes_memory;
    logic      is_skip;
  } dec_result_t;

endpackage

// ===== rtl/chip8_instruction_decoder.sv =====
// CHIP-8 instruction decoder top level: input register, decode, result register
// and the one-bit skip history. Depends on c8dec_pkg, c8dec_decode and the macros.
//
//   channel  | direction | tdata                          | tuser
//   s_axis   | in        | [15:0] opcode_word             | [0] first_in_block
//   m_axis   | out       | [5:0] instr_class, [21:6] regs | [0] ends_block, [1] writes_memory
//
// One opcode per cycle sustained while m_axis is ready; an opcode passes the input register, then the result register.
// The only feedback is the skip flag, updated as an item leaves the input register.
// rst clears both valid flags and the skip flag; payload registers are not reset.
// A stall on m_axis holds the result and, once the input register is full, s_axis.
`include "chip8_instruction_decoder_macros.svh"

module chip8_instruction_decoder
  import c8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] opcode_word
  input  logic        s_axis_tuser,  // [0] first_in_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [5:0] instr_class, [21:6] used_regs, [23:22] zero
  output logic [1:0]  m_axis_tuser   // [0] ends_block, [1] writes_memory
);

  logic        in_valid;
  logic [15:0] in_opcode;
  logic        in_first;
  logic        out_valid;
  dec_result_t out_result;
  logic        prev_was_skip;
  logic        advance;
  dec_result_t dec;
  logic        in_moves;
  logic        unknown_loud;

  // Pipeline control: the input stage moves on when the result register frees up
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  c8dec_decode u_decode (
    .opcode_word    (in_opcode),
    .first_in_block (in_first),
    .prev_was_skip  (prev_was_skip),
    .result         (dec)
  );

  // Valid flags and skip history
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      prev_was_skip <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance)       out_valid <= in_valid;
      if (in_valid && advance) prev_was_skip <= dec.is_skip;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode <= s_axis_tdata;
      in_first  <= s_axis_tuser;
    end
    if (in_valid && advance) out_result <= dec;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_result.used_regs, out_result.instr_class};
  assign m_axis_tuser  = {out_result.writes_memory, out_result.ends_block};

  // Terms for the checks below
  assign in_moves     = in_valid && advance;
  assign unknown_loud = out_valid && (out_result.instr_class == CLS_UNKNOWN) &&
                        (m_axis_tdata[21:6] != '0 || m_axis_tuser != 2'b00);

  // Checks on the decode and skip tracking
  `C8D_ASSERT_ALWAYS(a_class_range, !out_valid || m_axis_tdata[5:0] <= CLS_UNKNOWN, "bad class")
  `C8D_ASSERT_ALWAYS(a_unknown_quiet, !unknown_loud, "unknown opcode carries regs or flags")
  `C8D_ASSERT_ALWAYS(a_flags_exclusive, !out_valid || m_axis_tuser != 2'b11, "both flags set")
  `C8D_ASSERT_NEXT(a_skip_tracked, in_moves, prev_was_skip == $past(dec.is_skip), "skip lost")
  `C8D_ASSERT_NEXT(a_skip_hold, !in_moves, $stable(prev_was_skip), "skip changed while idle")

endmodule

// ===== rtl/c8dec_decode.sv =====
// Combinational decode of one CHIP-8 opcode into class, register mask and flags.
// Depends on c8dec_pkg.
module c8dec_decode
  import c8dec_pkg::*;
(
  input  logic [15:0] opcode_word,
  input  logic        first_in_block,
  input  logic        prev_was_skip,
  output dec_result_t result
);

  logic [3:0] grp;
  logic [3:0] x;
  logic [3:0] y;
  logic [3:0] n;
  logic [7:0] kk;
  class_t     cls;
  reg_mask_t  bx;
  reg_mask_t  bxy;
  reg_mask_t  range_mask;
  reg_mask_t  regs;
  logic       is_jump;
  logic       after_skip;

  assign grp = opcode_word[15:12];
  assign x   = opcode_word[11:8];
  assign y   = opcode_word[7:4];
  assign n   = opcode_word[3:0];
  assign kk  = opcode_word[7:0];

  // Class from group nibble and sub-selectors
  always_comb begin
    cls = CLS_UNKNOWN;
    unique case (grp)
      GRP_SYS: begin
        if (opcode_word == OP_CLS)      cls = CLS_CLS;
        else if (opcode_word == OP_RET) cls = CLS_RET;
        else                            cls = CLS_UNKNOWN;
      end
      GRP_JP:   cls = CLS_JP;
      GRP_CALL: cls = CLS_CALL;
      GRP_SE:   cls = CLS_SE_KK;
      GRP_SNE:  cls = CLS_SNE_KK;
      GRP_SEXY: cls = CLS_SE_XY;
      GRP_LD:   cls = CLS_LD_KK;
      GRP_ADD:  cls = CLS_ADD_KK;
      GRP_ALU: begin
        if (!n[3])          cls = CLS_LD_XY + class_t'(n[2:0]);
        else if (n == N_SHL) cls = CLS_SHL;
        else                 cls = CLS_UNKNOWN;
      end
      GRP_SNXY: cls = CLS_SNE_XY;
      GRP_LDI:  cls = CLS_LD_I;
      GRP_JPV0: cls = CLS_JP_V0;
      GRP_RND:  cls = CLS_RND;
      GRP_DRW:  cls = CLS_DRW;
      GRP_KEY: begin
        if (kk == KK_SKP)       cls = CLS_SKP;
        else if (kk == KK_SKNP) cls = CLS_SKNP;
        else                    cls = CLS_UNKNOWN;
      end
      GRP_MISC: begin
        unique case (kk)
          KK_DT_R:  cls = CLS_LD_DT_R;
          KK_KEY:   cls = CLS_LD_KEY;
          KK_DT_W:  cls = CLS_LD_DT_W;
          KK_ST:    cls = CLS_LD_ST;
          KK_ADD_I: cls = CLS_ADD_I;
          KK_F:     cls = CLS_LD_F;
          KK_BCD:   cls = CLS_LD_BCD;
          KK_STORE: cls = CLS_STORE;
          KK_LOAD:  cls = CLS_LOAD;
          default:  cls = CLS_UNKNOWN;
        endcase
      end
      default: cls = CLS_UNKNOWN;
    endcase
  end

  // Register masks: Vx, Vx|Vy, and V0..Vx for block store/load
  assign bx         = reg_mask_t'(1) << x;
  assign bxy        = bx | (reg_mask_t'(1) << y);
  assign range_mask = ~({{(RegCount-1){1'b1}}, 1'b0} << x);

  always_comb begin
    regs = bx;
    unique case (cls)
      CLS_CLS, CLS_RET, CLS_JP, CLS_CALL, CLS_LD_I, CLS_UNKNOWN:
        regs = '0;
      CLS_SE_XY, CLS_SNE_XY, CLS_LD_XY, CLS_OR, CLS_AND, CLS_XOR:
        regs = bxy;
      CLS_ADD_XY, CLS_SUB, CLS_SHR, CLS_SUBN, CLS_SHL, CLS_DRW:
        regs = bxy | VF_MASK;
      CLS_JP_V0:
        regs = reg_mask_t'(1);
      CLS_STORE, CLS_LOAD:
        regs = range_mask;
      default:
        regs = bx;
    endcase
  end

  // Control-flow flags; the skip memory is ignored at the start of a block
  assign is_jump    = (cls == CLS_RET) || (cls == CLS_JP) || (cls == CLS_CALL) ||
                      (cls == CLS_JP_V0);
  assign after_skip = !first_in_block && prev_was_skip;

  assign result.instr_class   = cls;
  assign result.used_regs     = regs;
  assign result.ends_block    = is_jump && !after_skip;
  assign result.writes_memory = (cls == CLS_LD_BCD) || (cls == CLS_STORE);
  assign result.is_skip       = (cls == CLS_SE_KK) || (cls == CLS_SNE_KK) ||
                                (cls == CLS_SE_XY) || (cls == CLS_SNE_XY) ||
                                (cls == CLS_SKP)   || (cls == CLS_SKNP);

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for chip8_instruction_decoder: drives opcodes over s_axis and
// checks every m_axis result against a decode model kept inside the bench.
// Depends on c8dec_pkg and the decoder RTL.
module tb;
  import c8dec_pkg::*;

  // Decoded form of one instruction, as the bench predicts it
  typedef struct packed {
    class_t    cls;
    reg_mask_t regs;
    logic      ends;
    logic      wr;
  } decoded_t;

  typedef enum int {PICK_ANY, PICK_SKIP, PICK_JUMP} pick_t;
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0;  // [15:0] opcode_word
  logic        s_axis_tuser = 1'b0;   // [0] first_in_block
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [5:0] instr_class, [21:6] used_regs, [23:22] zero
  logic [1:0]  m_axis_tuser;          // [0] ends_block, [1] writes_memory

  decoded_t expected_decodes[$];
  logic     last_was_skip = 1'b0;
  int       mismatches = 0;
  int       results_seen = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_count = 0;

  chip8_instruction_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Generous hard stop
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- decode model

  function automatic class_t classify(input logic [15:0] op);
    class_t c;
    c = CLS_UNKNOWN;
    case (op[15:12])
      GRP_SYS: begin
        if (op == OP_CLS) c = CLS_CLS;
        else if (op == OP_RET) c = CLS_RET;
      end
      GRP_JP:   c = CLS_JP;
      GRP_CALL: c = CLS_CALL;
      GRP_SE:   c = CLS_SE_KK;
      GRP_SNE:  c = CLS_SNE_KK;
      GRP_SEXY: c = CLS_SE_XY;   // low nibble ignored
      GRP_LD:   c = CLS_LD_KK;
      GRP_ADD:  c = CLS_ADD_KK;
      GRP_ALU: begin
        if (op[3:0] <= 4'd7) c = CLS_LD_XY + class_t'(op[3:0]);
        else if (op[3:0] == N_SHL) c = CLS_SHL;
      end
      GRP_SNXY: c = CLS_SNE_XY;  // low nibble ignored
      GRP_LDI:  c = CLS_LD_I;
      GRP_JPV0: c = CLS_JP_V0;
      GRP_RND:  c = CLS_RND;
      GRP_DRW:  c = CLS_DRW;
      GRP_KEY: begin
        if (op[7:0] == KK_SKP) c = CLS_SKP;
        else if (op[7:0] == KK_SKNP) c = CLS_SKNP;
      end
      default: begin
        case (op[7:0])
          KK_DT_R:  c = CLS_LD_DT_R;
          KK_KEY:   c = CLS_LD_KEY;
          KK_DT_W:  c = CLS_LD_DT_W;
          KK_ST:    c = CLS_LD_ST;
          KK_ADD_I: c = CLS_ADD_I;
          KK_F:     c = CLS_LD_F;
          KK_BCD:   c = CLS_LD_BCD;
          KK_STORE: c = CLS_STORE;
          KK_LOAD:  c = CLS_LOAD;
          default:  c = CLS_UNKNOWN;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic reg_mask_t reg_usage(input class_t c, input logic [15:0] op);
    reg_mask_t bx;
    reg_mask_t bxy;
    bx  = reg_mask_t'(1) << op[11:8];
    bxy = bx | (reg_mask_t'(1) << op[7:4]);
    case (c)
      CLS_CLS, CLS_RET, CLS_JP, CLS_CALL, CLS_LD_I, CLS_UNKNOWN: return '0;
      CLS_SE_XY, CLS_SNE_XY, CLS_LD_XY, CLS_OR, CLS_AND, CLS_XOR: return bxy;
      // VF touched as carry, borrow, shift-out or collision flag
      CLS_ADD_XY, CLS_SUB, CLS_SHR, CLS_SUBN, CLS_SHL, CLS_DRW: return bxy | VF_MASK;
      CLS_JP_V0: return reg_mask_t'(1);
      // V0..Vx; wraps to all ones for x = F
      CLS_STORE, CLS_LOAD: return (bx << 1) - reg_mask_t'(1);
      default: return bx;
    endcase
  endfunction

  // Decodes one opcode and moves the skip history on by one instruction
  function automatic decoded_t predict_decode(input logic [15:0] op, input logic first);
    decoded_t d;
    logic     after_skip;
    d.cls      = classify(op);
    d.regs     = reg_usage(d.cls, op);
    after_skip = !first && last_was_skip;
    d.ends     = (d.cls inside {CLS_RET, CLS_JP, CLS_CALL, CLS_JP_V0}) && !after_skip;
    d.wr       = (d.cls == CLS_LD_BCD) || (d.cls == CLS_STORE);
    last_was_skip = d.cls inside {CLS_SE_KK, CLS_SNE_KK, CLS_SE_XY, CLS_SNE_XY,
                                  CLS_SKP, CLS_SKNP};
    return d;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %s at result %0d: got %0h, expected %0h",
             field, results_seen, got, want);
    mismatches++;
  endtask

  // Result check first, then prediction of any opcode taken on the same edge
  always @(posedge clk) begin
    decoded_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_decodes.size() == 0) begin
          report_mismatch("result with nothing pending", m_axis_tdata[15:0], 16'h0);
        end else begin
          want = expected_decodes.pop_front();
          if (m_axis_tdata[5:0] !== want.cls)
            report_mismatch("instr_class", 16'(m_axis_tdata[5:0]), 16'(want.cls));
          if (m_axis_tdata[21:6] !== want.regs)
            report_mismatch("used_regs", m_axis_tdata[21:6], want.regs);
          if (m_axis_tuser[0] !== want.ends)
            report_mismatch("ends_block", 16'(m_axis_tuser[0]), 16'(want.ends));
          if (m_axis_tuser[1] !== want.wr)
            report_mismatch("writes_memory", 16'(m_axis_tuser[1]), 16'(want.wr));
          if (m_axis_tdata[23:22] !== 2'b00)
            report_mismatch("tdata padding", 16'(m_axis_tdata[23:22]), 16'h0);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_decodes.push_back(predict_decode(s_axis_tdata, s_axis_tuser));
    end
  end

  // ---------------------------------------------------------------- receiver

  // Back-pressure mode is redrawn at random whenever the low six bits of rx_count are zero
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= rx_count[2];
    endcase
  end

  // ---------------------------------------------------------------- sender

  // Called on a rising edge; returns on the edge where the transaction is taken
  task automatic send_opcode(input logic [15:0] op, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= op;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
  endtask

  // Mostly well-formed opcodes with random operands; some raw noise
  function automatic logic [15:0] random_opcode(input pick_t pick);
    logic [15:0] op;
    op = 16'($urandom);
    case (pick)
      PICK_SKIP: begin
        case ($urandom_range(0, 4))
          0:       op[15:12] = GRP_SE;
          1:       op[15:12] = GRP_SNE;
          2:       op[15:12] = GRP_SEXY;
          3:       op[15:12] = GRP_SNXY;
          default: op[15:12] = GRP_KEY;
        endcase
      end
      PICK_JUMP: begin
        case ($urandom_range(0, 3))
          0:       op[15:12] = GRP_SYS;
          1:       op[15:12] = GRP_JP;
          2:       op[15:12] = GRP_CALL;
          default: op[15:12] = GRP_JPV0;
        endcase
      end
      default: ;
    endcase
    if (pick != PICK_ANY || $urandom_range(0, 6) != 0) begin
      case (op[15:12])
        GRP_SYS: op = ($urandom_range(0, 2) == 0) ? OP_CLS : OP_RET;
        GRP_ALU: op[3:0] = ($urandom_range(0, 8) == 8) ? N_SHL : 4'($urandom_range(0, 7));
        GRP_KEY: op[7:0] = $urandom_range(0, 1) ? KK_SKP : KK_SKNP;
        GRP_MISC: begin
          case ($urandom_range(0, 8))
            0:       op[7:0] = KK_DT_R;
            1:       op[7:0] = KK_KEY;
            2:       op[7:0] = KK_DT_W;
            3:       op[7:0] = KK_ST;
            4:       op[7:0] = KK_ADD_I;
            5:       op[7:0] = KK_F;
            6:       op[7:0] = KK_BCD;
            7:       op[7:0] = KK_STORE;
            default: op[7:0] = KK_LOAD;
          endcase
        end
        default: ;
      endcase
    end
    return op;
  endfunction

  // ---------------------------------------------------------------- tests

  // At least one opcode per class, with operand extremes and the undefined encodings
  task automatic test_every_class();
    send_opcode(OP_CLS, 1'b1);
    send_opcode(OP_RET, 1'b1);
    send_opcode(16'h0000, 1'b0);
    send_opcode(16'h0FFF, 1'b0);
    send_opcode(16'h1FFF, 1'b0);
    send_opcode(16'h2000, 1'b0);
    send_opcode(16'h3F00, 1'b0);
    send_opcode(16'h40FF, 1'b0);
    send_opcode(16'h5FF0, 1'b0);
    send_opcode(16'h501F, 1'b0);   // compare skip with non-zero low nibble
    send_opcode(16'h6000, 1'b0);
    send_opcode(16'h7FFF, 1'b0);
    send_opcode(16'h80F0, 1'b0);
    send_opcode(16'h8F01, 1'b0);
    send_opcode(16'h8122, 1'b0);
    send_opcode(16'h8343, 1'b0);
    send_opcode(16'h8FF4, 1'b0);
    send_opcode(16'h8565, 1'b0);
    send_opcode(16'h8786, 1'b0);
    send_opcode(16'h8007, 1'b0);
    send_opcode(16'h8FFE, 1'b0);
    send_opcode(16'h8128, 1'b0);   // undefined ALU op
    send_opcode(16'h8FFF, 1'b0);
    send_opcode(16'h9ABF, 1'b0);
    send_opcode(16'hAFFF, 1'b0);
    send_opcode(16'hB123, 1'b0);
    send_opcode(16'hC0FF, 1'b0);
    send_opcode(16'hDFFF, 1'b0);
    send_opcode(16'hE09E, 1'b0);
    send_opcode(16'hEFA1, 1'b0);
    send_opcode(16'hE5FF, 1'b0);   // undefined key op
    send_opcode(16'hF007, 1'b0);
    send_opcode(16'hF10A, 1'b0);
    send_opcode(16'hF215, 1'b0);
    send_opcode(16'hF318, 1'b0);
    send_opcode(16'hF41E, 1'b0);
    send_opcode(16'hF529, 1'b0);
    send_opcode(16'hF633, 1'b0);
    send_opcode(16'hF055, 1'b0);   // store V0 only
    send_opcode(16'hFF55, 1'b0);   // store V0..VF
    send_opcode(16'hFF65, 1'b0);
    send_opcode(16'hF765, 1'b0);
    send_opcode(16'hFFFF, 1'b0);   // undefined misc op
  endtask

  // Jumps after a skip, after a non-skip and at the head of a block
  task automatic test_skip_history();
    send_opcode(16'h3A12, 1'b1);
    send_opcode(16'h1234, 1'b0);   // guarded by the skip
    send_opcode(16'hE1A1, 1'b0);
    send_opcode(16'h2FFF, 1'b1);   // new block: skip forgotten
    send_opcode(16'h9120, 1'b0);
    send_opcode(16'h5340, 1'b0);
    send_opcode(16'hB000, 1'b0);   // two skips, then JP V0
    send_opcode(16'h6000, 1'b0);
    send_opcode(OP_RET, 1'b0);     // not preceded by a skip
    send_opcode(16'hE29E, 1'b0);
    send_opcode(OP_RET, 1'b0);
  endtask

  // Random stream, heavy on skip-then-jump pairs
  task automatic test_random_stream(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        send_opcode(random_opcode(PICK_SKIP), $urandom_range(0, 9) == 0);
        send_opcode(random_opcode(PICK_JUMP), $urandom_range(0, 5) == 0);
        sent += 2;
      end else begin
        send_opcode(random_opcode(PICK_ANY), $urandom_range(0, 4) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_every_class();
    test_skip_history();
    test_random_stream(700);
    s_axis_tvalid <= 1'b0;
    // wait so the last transaction is surely queued before draining
    @(posedge clk);
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
